@@ hw/rtl/flc_pkg.sv @@
package flc_pkg;

   // default depth of the impulse response
   localparam int MAX_TAPS_DEF = 32;

   // field widths
   localparam int DATA_W      = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 37;
   localparam int TAP_COUNT_W = 6;
   localparam int TAP_INDEX_W = 5;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 6'd32;

   // request kinds
   typedef enum logic {
      KIND_TAP    = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_EMIT
   } state_type;

   // sequencer controls to the datapath
   typedef struct packed {
      logic shift_en;
      logic shift_zero;
      logic win_clear;
      logic issue;
      logic acc_clr;
      logic out_load;
      logic out_last;
   } ctrl_type;

endpackage

@@ hw/rtl/flc_if.sv @@
interface flc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [flc_pkg::TAP_INDEX_W-1:0]     tap_index;
   logic signed [flc_pkg::DATA_W-1:0]   tap_value;
   logic signed [flc_pkg::DATA_W-1:0]   sample_value;
   logic                                last_sample;

   modport source (output valid, kind, tap_index, tap_value, sample_value, last_sample,
                   input ready);
   modport sink (input valid, kind, tap_index, tap_value, sample_value, last_sample,
                 output ready);
endinterface

interface flc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [flc_pkg::ACC_W-1:0]   output_value;
   logic                               last_output;

   modport source (output valid, output_value, last_output, input ready);
   modport sink (input valid, output_value, last_output, output ready);
endinterface

@@ hw/rtl/flc_tap_store.sv @@
module flc_tap_store #(
   parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF,
   parameter int IDX_W    = $clog2(MAX_TAPS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [IDX_W-1:0]                  wr_idx,
   input  logic signed [flc_pkg::DATA_W-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [IDX_W-1:0]                  rd_idx,
   output logic signed [flc_pkg::DATA_W-1:0] rd_data
);

   logic signed [flc_pkg::DATA_W-1:0] mem_ff [MAX_TAPS];
   logic [MAX_TAPS-1:0]               vld_ff;
   logic signed [flc_pkg::DATA_W-1:0] rd_data_ff;

   // mark written entries; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   // write coefficient
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_idx] ? mem_ff[rd_idx] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/flc_window.sv @@
module flc_window #(
   parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF,
   parameter int IDX_W    = $clog2(MAX_TAPS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  flc_pkg::ctrl_type                 ctrl,
   input  logic signed [flc_pkg::DATA_W-1:0] sample_in,
   input  logic [IDX_W-1:0]                  rd_idx,
   output logic signed [flc_pkg::DATA_W-1:0] rd_data
);

   // win_ff[0] is the newest sample, win_ff[k] the sample k steps back
   logic signed [flc_pkg::DATA_W-1:0] win_ff [MAX_TAPS];
   logic signed [flc_pkg::DATA_W-1:0] rd_data_ff;

   // shift in a sample or a flush zero, clear at end of signal
   always_ff @(posedge clock) begin
      if (reset || ctrl.win_clear) begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (ctrl.shift_en) begin
         win_ff[0] <= ctrl.shift_zero ? '0 : sample_in;
         for (int k = 1; k < MAX_TAPS; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // registered read of one tap position
   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         rd_data_ff <= win_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/flc_mac.sv @@
module flc_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  flc_pkg::ctrl_type                 ctrl,
   input  logic signed [flc_pkg::DATA_W-1:0] tap_rd,
   input  logic signed [flc_pkg::DATA_W-1:0] win_rd,
   output logic signed [flc_pkg::ACC_W-1:0]  acc,
   output logic                              busy
);

   logic                              op_vld_ff;
   logic                              prod_vld_ff;
   logic signed [flc_pkg::PROD_W-1:0] prod_ff;
   logic signed [flc_pkg::PROD_W-1:0] prod_in;
   logic signed [flc_pkg::ACC_W-1:0]  acc_ff;
   logic signed [flc_pkg::ACC_W-1:0]  acc_in;

   // track operands and products in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         op_vld_ff   <= ctrl.issue;
         prod_vld_ff <= op_vld_ff;
      end
   end

   // multiply stage
   assign prod_in = tap_rd * win_rd;

   always_ff @(posedge clock) begin
      if (op_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage, wraps at the accumulator width
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + flc_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = op_vld_ff | prod_vld_ff;

endmodule

@@ hw/rtl/flc_seq.sv @@
module flc_seq #(
   parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF,
   parameter int IDX_W    = $clog2(MAX_TAPS),
   parameter int CNT_W    = $clog2(MAX_TAPS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_kind,
   input  logic              req_last,
   input  logic [CNT_W-1:0]  taps,
   input  logic              out_free,
   input  logic              mac_busy,
   output logic              req_ready,
   output flc_pkg::ctrl_type ctrl,
   output logic [IDX_W-1:0]  rd_idx
);

   flc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   taps_ff, taps_in;
   logic [CNT_W-1:0]   tail_ff, tail_in;
   logic               last_ff, last_in;
   logic               accept_sample;
   logic               issue_done;
   logic               restart;

   assign accept_sample = (state_ff == flc_pkg::S_IDLE) && req_valid &&
                          (req_kind == flc_pkg::KIND_SAMPLE);
   assign issue_done    = (j_ff == taps_ff - CNT_W'(1));
   assign restart       = (state_ff == flc_pkg::S_EMIT) && out_free && (tail_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         flc_pkg::S_IDLE: begin
            if (accept_sample) begin
               state_in = flc_pkg::S_ISSUE;
            end
         end
         flc_pkg::S_ISSUE: begin
            if (issue_done) begin
               state_in = flc_pkg::S_DRAIN;
            end
         end
         flc_pkg::S_DRAIN: begin
            if (!mac_busy) begin
               state_in = flc_pkg::S_EMIT;
            end
         end
         flc_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = (tail_ff != '0) ? flc_pkg::S_ISSUE : flc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = flc_pkg::S_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      req_ready       = (state_ff == flc_pkg::S_IDLE);
      ctrl            = '0;
      ctrl.shift_en   = accept_sample || restart;
      ctrl.shift_zero = (state_ff == flc_pkg::S_EMIT);
      ctrl.acc_clr    = accept_sample || restart;
      ctrl.issue      = (state_ff == flc_pkg::S_ISSUE);
      ctrl.out_load   = (state_ff == flc_pkg::S_EMIT) && out_free;
      ctrl.out_last   = last_ff && (tail_ff == '0);
      ctrl.win_clear  = ctrl.out_load && ctrl.out_last;
   end

   assign rd_idx = j_ff[IDX_W-1:0];

   // tap counter, tail counter and signal end flag
   always_comb begin
      j_in    = j_ff;
      taps_in = taps_ff;
      tail_in = tail_ff;
      last_in = last_ff;
      if (accept_sample) begin
         j_in    = '0;
         taps_in = taps;
         tail_in = req_last ? taps - CNT_W'(1) : '0;
         last_in = req_last;
      end else if (restart) begin
         j_in    = '0;
         tail_in = tail_ff - CNT_W'(1);
      end else if (state_ff == flc_pkg::S_ISSUE) begin
         j_in = j_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flc_pkg::S_IDLE;
         j_ff     <= '0;
         taps_ff  <= CNT_W'(1);
         tail_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         taps_ff  <= taps_in;
         tail_ff  <= tail_in;
         last_ff  <= last_in;
      end
   end

   // results leave only once the multiply-accumulate pipeline is empty
   assert property (@(posedge clock) disable iff (reset) ctrl.out_load |-> !mac_busy)
      else $error("output loaded while products are still in flight");

   // the window never moves under a running sum
   assert property (@(posedge clock) disable iff (reset) ctrl.shift_en |-> !mac_busy)
      else $error("window shifted during accumulation");

   // tap reads stay within the taps in use
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == flc_pkg::S_ISSUE) |-> (j_ff < taps_ff))
      else $error("tap index beyond taps in use");

   // after a result, either the next tail sum starts or the block goes idle
   assert property (@(posedge clock) disable iff (reset)
                    ctrl.out_load |=> (state_ff == flc_pkg::S_IDLE ||
                                       state_ff == flc_pkg::S_ISSUE))
      else $error("unexpected state after result");

endmodule

@@ hw/rtl/full_linear_convolution_core.sv @@
// One shared 16x16 multiply-accumulate takes one tap per cycle while a sum is issued.
// A sample request holds the input until its result, and after the last sample every
// tail output, is loaded into the output register; tap loads are taken only while idle,
// even while a result waits.
// Reset (synchronous, active high) makes the coefficients read as zero, zeroes the delay
// line and sets the tap count to 32.
module full_linear_convolution_core #(
   parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   flc_req_if.sink                              req,
   flc_rsp_if.source                            rsp,
   input  logic                                 csr_we,
   input  logic [flc_pkg::TAP_COUNT_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(MAX_TAPS);
   localparam int CNT_W = $clog2(MAX_TAPS + 1);

   logic [flc_pkg::TAP_COUNT_W-1:0]   tap_count_ff;
   logic [CNT_W-1:0]                  taps_use;
   logic                              tap_wr;
   logic [IDX_W-1:0]                  rd_idx;
   logic signed [flc_pkg::DATA_W-1:0] tap_rd;
   logic signed [flc_pkg::DATA_W-1:0] win_rd;
   logic signed [flc_pkg::ACC_W-1:0]  acc;
   logic                              mac_busy;
   logic                              out_free;
   flc_pkg::ctrl_type                 ctrl;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [flc_pkg::ACC_W-1:0]  rsp_value_ff;
   logic                              rsp_last_ff;

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= flc_pkg::TAP_COUNT_RST;
      end else if (csr_we) begin
         tap_count_ff <= csr_wdata;
      end
   end

   // clamp the tap count to 1..MAX_TAPS
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_use = CNT_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         taps_use = CNT_W'(MAX_TAPS);
      end else begin
         taps_use = CNT_W'(tap_count_ff);
      end
   end

   // coefficient load; drop indexes beyond the store
   assign tap_wr = req.valid && req.ready && (req.kind == flc_pkg::KIND_TAP) &&
                   (int'(req.tap_index) < MAX_TAPS);

   flc_seq #(
      .MAX_TAPS (MAX_TAPS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.kind),
      .req_last  (req.last_sample),
      .taps      (taps_use),
      .out_free  (out_free),
      .mac_busy  (mac_busy),
      .req_ready (req.ready),
      .ctrl      (ctrl),
      .rd_idx    (rd_idx)
   );

   flc_tap_store #(
      .MAX_TAPS (MAX_TAPS),
      .IDX_W    (IDX_W)
   ) u_tap_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tap_wr),
      .wr_idx  (IDX_W'(req.tap_index)),
      .wr_data (req.tap_value),
      .rd_en   (ctrl.issue),
      .rd_idx  (rd_idx),
      .rd_data (tap_rd)
   );

   flc_window #(
      .MAX_TAPS (MAX_TAPS),
      .IDX_W    (IDX_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .sample_in (req.sample_value),
      .rd_idx    (rd_idx),
      .rd_data   (win_rd)
   );

   flc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .tap_rd (tap_rd),
      .win_rd (win_rd),
      .acc    (acc),
      .busy   (mac_busy)
   );

   // output register: load a finished sum, hold until taken
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_value_ff <= acc;
         rsp_last_ff  <= ctrl.out_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.output_value = rsp_value_ff;
   assign rsp.last_output  = rsp_last_ff;

endmodule
